>>> rtl/sshc_pkg.sv
// Shared widths, limits and register indexes for the sensor spike filter.
package sshc_pkg;

    localparam int unsigned READING_W = 15;
    localparam int unsigned HUMID_OUT_W = 10;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned SCALED_W = 12;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned NUM_CHANNELS = 4;

    localparam logic [READING_W-1:0] HUMID_MAX = 15'd1000;
    localparam logic [READING_W-1:0] TEMP_HIGH_LIMIT = 15'd1700;
    localparam logic [READING_W-1:0] TEMP_LOW_LIMIT = 15'd100;
    localparam logic [READING_W-1:0] HUMID_LOW_LIMIT = 15'd10;
    localparam logic [READING_W-1:0] JUMP_THRESHOLD_RST = 15'd50;
    localparam logic [COUNT_W-1:0] CONFIRM_COUNT_RST = 4'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HEAT_ON_BELOW   = 3'd0,
        CFG_HEAT_OFF_AT     = 3'd1,
        CFG_HUMID_ON_AT     = 3'd2,
        CFG_HUMID_OFF_BELOW = 3'd3,
        CFG_JUMP_THRESHOLD  = 3'd4,
        CFG_CONFIRM_COUNT   = 3'd5
    } t_cfg_idx;

endpackage

>>> rtl/sensor_spike_filter_hysteresis_ctrl.sv
// Two-sensor spike filter with heat and humidify hysteresis requests.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  input   | in        | i_in_valid / o_in_ready   | readings, fresh flags, alive, manual
//  result  | out       | o_out_valid / i_out_ready | filtered readings, requests, ok
//  config  | in        | i_cfg_we (no wait)        | i_cfg_addr, i_cfg_wdata
//
// One beat per cycle sustained while the result is not stalled; an accepted beat loads
// stage one and then the result register, whose load raises o_out_valid.
// Stage one updates the references and jump counters on acceptance; stage two
// runs the hysteresis on the new references and loads the result register.
// A stalled result holds stage two, and input is taken only while stage one can move on.
// Synchronous active-low reset clears references, counters, flags and valids.
module sensor_spike_filter_hysteresis_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sshc_pkg::READING_W-1:0]      i_temp_a,
    input  logic [sshc_pkg::READING_W-1:0]      i_humid_a,
    input  logic                                i_fresh_a,
    input  logic [sshc_pkg::READING_W-1:0]      i_temp_b,
    input  logic [sshc_pkg::READING_W-1:0]      i_humid_b,
    input  logic                                i_fresh_b,
    input  logic                                i_sensor_alive,
    input  logic                                i_manual_active,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sshc_pkg::READING_W-1:0]      o_filt_temp_a,
    output logic [sshc_pkg::HUMID_OUT_W-1:0]    o_filt_humid_a,
    output logic [sshc_pkg::READING_W-1:0]      o_filt_temp_b,
    output logic [sshc_pkg::HUMID_OUT_W-1:0]    o_filt_humid_b,
    output logic                                o_heat_request,
    output logic                                o_humidify_request,
    output logic                                o_sensor_ok,
    input  logic                                i_cfg_we,
    input  logic [sshc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sshc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int unsigned RW = sshc_pkg::READING_W;
    localparam int unsigned CW = sshc_pkg::COUNT_W;
    localparam int unsigned SW = sshc_pkg::SCALED_W;

    // configuration
    logic [sshc_pkg::LEVEL_W-1:0] r_heat_on_below, r_heat_off_at;
    logic [sshc_pkg::LEVEL_W-1:0] r_humid_on_at, r_humid_off_below;
    logic [RW-1:0]                r_jump_threshold;
    logic [CW-1:0]                r_confirm_count;

    // filter state, order temp_a, humid_a, temp_b, humid_b
    logic [RW-1:0] r_ref [sshc_pkg::NUM_CHANNELS];
    logic [CW-1:0] r_cnt [sshc_pkg::NUM_CHANNELS];
    logic [RW-1:0] n_ref [sshc_pkg::NUM_CHANNELS];
    logic [CW-1:0] n_cnt [sshc_pkg::NUM_CHANNELS];
    logic [RW-1:0] now   [sshc_pkg::NUM_CHANNELS];
    logic          fresh [sshc_pkg::NUM_CHANNELS];

    // stage one control
    logic r_s1_valid, r_s1_alive, r_s1_manual;

    // result and hysteresis state
    logic          r_out_valid;
    logic          r_heat_flag, r_humid_flag, r_ok_flag;
    logic          n_heat_flag, n_humid_flag, n_ok_flag;
    logic [RW-1:0] r_filt_temp_a, r_filt_temp_b;
    logic [sshc_pkg::HUMID_OUT_W-1:0] r_filt_humid_a, r_filt_humid_b;

    logic          out_free, s1_move, in_take;
    logic [RW-1:0] sat_humid_a, sat_humid_b;
    logic [SW-1:0] heat_on10, heat_off10, humid_on10, humid_off10;

    function automatic logic [RW-1:0] sat_humid(input logic [RW-1:0] v);
        return (v > sshc_pkg::HUMID_MAX) ? sshc_pkg::HUMID_MAX : v;
    endfunction

    // times ten as shift and add; 255 * 10 fits in twelve bits
    function automatic logic [SW-1:0] times_ten(input logic [sshc_pkg::LEVEL_W-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return (w << 3) + (w << 1);
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_on_below   <= '0;
            r_heat_off_at     <= '0;
            r_humid_on_at     <= '0;
            r_humid_off_below <= '0;
            r_jump_threshold  <= sshc_pkg::JUMP_THRESHOLD_RST;
            r_confirm_count   <= sshc_pkg::CONFIRM_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (sshc_pkg::t_cfg_idx'(i_cfg_addr))
                sshc_pkg::CFG_HEAT_ON_BELOW:   r_heat_on_below   <= i_cfg_wdata[7:0];
                sshc_pkg::CFG_HEAT_OFF_AT:     r_heat_off_at     <= i_cfg_wdata[7:0];
                sshc_pkg::CFG_HUMID_ON_AT:     r_humid_on_at     <= i_cfg_wdata[7:0];
                sshc_pkg::CFG_HUMID_OFF_BELOW: r_humid_off_below <= i_cfg_wdata[7:0];
                sshc_pkg::CFG_JUMP_THRESHOLD:  r_jump_threshold  <= i_cfg_wdata[RW-1:0];
                sshc_pkg::CFG_CONFIRM_COUNT:   r_confirm_count   <= i_cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    assign now[0]   = i_temp_a;
    assign now[1]   = i_humid_a;
    assign now[2]   = i_temp_b;
    assign now[3]   = i_humid_b;
    assign fresh[0] = i_fresh_a;
    assign fresh[1] = i_fresh_a;
    assign fresh[2] = i_fresh_b;
    assign fresh[3] = i_fresh_b;

    // spike filter, one lane per reading
    always_comb begin
        logic [RW-1:0] diff;
        logic [CW-1:0] cnt_inc;
        for (int k = 0; k < sshc_pkg::NUM_CHANNELS; k++) begin
            n_ref[k] = r_ref[k];
            n_cnt[k] = r_cnt[k];
            diff     = (r_ref[k] > now[k]) ? (r_ref[k] - now[k]) : (now[k] - r_ref[k]);
            cnt_inc  = (r_cnt[k] < sshc_pkg::COUNT_MAX) ? (r_cnt[k] + CW'(1)) : r_cnt[k];
            if (fresh[k]) begin
                if (r_ref[k] == '0) begin
                    // empty reference: take the reading, leave the counter alone
                    n_ref[k] = now[k];
                end else if (diff >= r_jump_threshold) begin
                    if (cnt_inc >= r_confirm_count) begin
                        n_cnt[k] = '0;
                        n_ref[k] = now[k];
                    end else begin
                        n_cnt[k] = cnt_inc;
                    end
                end else begin
                    n_cnt[k] = '0;
                    n_ref[k] = now[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int k = 0; k < sshc_pkg::NUM_CHANNELS; k++) begin
                r_ref[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
                for (int k = 0; k < sshc_pkg::NUM_CHANNELS; k++) begin
                    r_ref[k] <= n_ref[k];
                    r_cnt[k] <= n_cnt[k];
                end
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_alive  <= i_sensor_alive;
            r_s1_manual <= i_manual_active;
        end
    end

    // hysteresis on the references left by the beat in stage one
    assign sat_humid_a = sat_humid(r_ref[1]);
    assign sat_humid_b = sat_humid(r_ref[3]);
    assign heat_on10   = times_ten(r_heat_on_below);
    assign heat_off10  = times_ten(r_heat_off_at);
    assign humid_on10  = times_ten(r_humid_on_at);
    assign humid_off10 = times_ten(r_humid_off_below);

    always_comb begin
        n_heat_flag  = r_heat_flag;
        n_humid_flag = r_humid_flag;
        n_ok_flag    = r_ok_flag;
        if (!r_s1_manual) begin
            if (r_s1_alive) begin
                n_ok_flag = 1'b1;
                if (r_ref[0] > sshc_pkg::TEMP_HIGH_LIMIT || r_ref[0] < sshc_pkg::TEMP_LOW_LIMIT)
                    n_heat_flag = 1'b0;
                if (r_ref[0] > sshc_pkg::TEMP_LOW_LIMIT && r_ref[0] < RW'(heat_on10))
                    n_heat_flag = 1'b1;
                if (r_ref[0] >= RW'(heat_off10))
                    n_heat_flag = 1'b0;
                if (sat_humid_a > sshc_pkg::HUMID_LOW_LIMIT && sat_humid_a >= RW'(humid_on10))
                    n_humid_flag = 1'b1;
                if (sat_humid_a < RW'(humid_off10))
                    n_humid_flag = 1'b0;
            end else begin
                // sensor lost: drop both requests
                n_ok_flag    = 1'b0;
                n_heat_flag  = 1'b0;
                n_humid_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_heat_flag  <= 1'b0;
            r_humid_flag <= 1'b0;
            r_ok_flag    <= 1'b0;
        end else begin
            if (s1_move) begin
                r_out_valid  <= 1'b1;
                r_heat_flag  <= n_heat_flag;
                r_humid_flag <= n_humid_flag;
                r_ok_flag    <= n_ok_flag;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_filt_temp_a  <= r_ref[0];
            r_filt_humid_a <= sat_humid_a[sshc_pkg::HUMID_OUT_W-1:0];
            r_filt_temp_b  <= r_ref[2];
            r_filt_humid_b <= sat_humid_b[sshc_pkg::HUMID_OUT_W-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_filt_temp_a      = r_filt_temp_a;
    assign o_filt_humid_a     = r_filt_humid_a;
    assign o_filt_temp_b      = r_filt_temp_b;
    assign o_filt_humid_b     = r_filt_humid_b;
    assign o_heat_request     = r_heat_flag;
    assign o_humidify_request = r_humid_flag;
    assign o_sensor_ok        = r_ok_flag;

endmodule
